>>> sv/bts_pkg.sv
// Shared constants, register codes and helpers for the tap search block.
package bts_pkg;

   localparam int BER_WIDTH  = 63;
   localparam int DIST_WIDTH = 64;

   localparam int SCAN_STEPS_DEFAULT  = 11;
   localparam int MAX_RETRIES_DEFAULT = 3;
   localparam int TAP_WIDTH_DEFAULT   = 10;

   localparam int RETRY_WIDTH = 2;
   localparam int CSR_ADDR_WIDTH = 4;
   localparam int CSR_DATA_WIDTH = 64;

   typedef logic [BER_WIDTH-1:0]  ber_type;
   typedef logic [DIST_WIDTH-1:0] dist_type;

   // "no point yet" marker (2.0) and 1.0 in 62-fraction-bit fixed point
   localparam dist_type BER_NONE = 64'h8000_0000_0000_0000;
   localparam dist_type BER_ONE  = 64'h4000_0000_0000_0000;

   localparam ber_type  TARGET_RESET      = 63'd461168602;
   localparam dist_type DIST_RESET        = BER_NONE - {1'b0, TARGET_RESET};

   // register index, taken from paddr[3]
   typedef enum logic {
      CSR_TARGET_BER = 1'b0
   } csr_index_type;

   function automatic dist_type ber_dist(input dist_type a, input dist_type b);
      return (a >= b) ? (a - b) : (b - a);
   endfunction

endpackage

>>> sv/ber_target_tap_search.sv
// Successive-approximation tap search against a target bit error rate.
//
// req_ channel: one measurement beat per step (measured_ber, measure_failed)
// taken at the tap last reported on rsp_next_tap. rsp_ channel: exactly one
// result beat per request beat, in order. csr_ port: APB-style, 64-bit data,
// target_ber at byte address 0; write it only while no beat is in flight.
//
// A request beat goes into the input register, then through the step/compare
// logic into the result register. Throughput is one beat per cycle while
// rsp_ready is high; the step, tracking and final selection are all resolved
// in that single compare/add stage.
//
// Reset (synchronous, active high) arms a fresh scan at the all-ones tap
// with half-range step, clears the tracked points and loads the default
// target. When rsp_ready is low the result register holds its beat and the
// input register can still take one more beat; req_ready drops only when
// both are full. A finished scan rearms itself and next_tap returns to the
// start tap.
module ber_target_tap_search #(
   parameter int SCAN_STEPS  = bts_pkg::SCAN_STEPS_DEFAULT,
   parameter int MAX_RETRIES = bts_pkg::MAX_RETRIES_DEFAULT,
   parameter int TAP_WIDTH   = bts_pkg::TAP_WIDTH_DEFAULT
) (
   input  logic                                clock,
   input  logic                                reset,

   input  logic                                req_valid,
   output logic                                req_ready,
   input  logic [bts_pkg::BER_WIDTH-1:0]       req_measured_ber,
   input  logic                                req_measure_failed,

   output logic                                rsp_valid,
   input  logic                                rsp_ready,
   output logic [TAP_WIDTH-1:0]                rsp_next_tap,
   output logic                                rsp_retrying,
   output logic                                rsp_scan_done,
   output logic                                rsp_over_target_at_start,
   output logic [TAP_WIDTH-1:0]                rsp_chosen_tap,
   output logic                                rsp_fit_possible,

   input  logic                                csr_psel,
   input  logic                                csr_penable,
   input  logic                                csr_pwrite,
   input  logic [bts_pkg::CSR_ADDR_WIDTH-1:0]  csr_paddr,
   input  logic [bts_pkg::CSR_DATA_WIDTH-1:0]  csr_pwdata,
   output logic [bts_pkg::CSR_DATA_WIDTH-1:0]  csr_prdata,
   output logic                                csr_pready
);

   localparam int IDX_W = $clog2(SCAN_STEPS);
   localparam logic [TAP_WIDTH-1:0] TAP_START  = {TAP_WIDTH{1'b1}};
   localparam logic [TAP_WIDTH-1:0] STEP_START = TAP_WIDTH'(1) << (TAP_WIDTH - 1);

   // configuration
   bts_pkg::ber_type  target_ff;
   logic              csr_wr;
   bts_pkg::ber_type  wr_target;

   // input register
   logic              in_valid_ff;
   bts_pkg::ber_type  in_ber_ff;
   logic              in_failed_ff;

   // scan state
   logic [TAP_WIDTH-1:0]            tap_ff;
   logic [TAP_WIDTH-1:0]            step_ff;
   logic [IDX_W-1:0]                idx_ff;
   logic [bts_pkg::RETRY_WIDTH-1:0] retry_ff;
   bts_pkg::dist_type               above_ber_ff;
   bts_pkg::dist_type               below_ber_ff;
   bts_pkg::dist_type               above_dist_ff;
   bts_pkg::dist_type               below_dist_ff;
   logic [TAP_WIDTH-1:0]            above_tap_ff;
   logic [TAP_WIDTH-1:0]            below_tap_ff;

   // result register
   logic                  out_valid_ff;
   logic [TAP_WIDTH-1:0]  out_next_tap_ff;
   logic                  out_retrying_ff;
   logic                  out_done_ff;
   logic                  out_over_ff;
   logic [TAP_WIDTH-1:0]  out_chosen_ff;
   logic                  out_fit_ff;

   // step logic
   logic                  advance;
   bts_pkg::dist_type     ber64;
   bts_pkg::dist_type     tgt64;
   bts_pkg::dist_type     d;
   logic                  is_retry;
   logic                  has_rate;
   logic                  track;
   logic                  ge_target;
   logic                  upd_above;
   logic                  upd_below;
   logic                  pick_above;
   logic                  above_le_one;
   logic                  below_lt_target;
   logic                  up;
   logic                  over;
   logic [IDX_W:0]        next_idx;
   logic                  done;
   logic [TAP_WIDTH-1:0]  tap_in;
   logic [TAP_WIDTH-1:0]  chosen_in;
   logic [TAP_WIDTH-1:0]  new_above_tap;
   logic [TAP_WIDTH-1:0]  new_below_tap;

   // ---------------- configuration port ----------------
   assign csr_pready = 1'b1;
   assign wr_target  = csr_pwdata[bts_pkg::BER_WIDTH-1:0];
   assign csr_wr     = csr_psel && csr_penable && csr_pwrite && csr_pready &&
                       (bts_pkg::csr_index_type'(csr_paddr[3]) == bts_pkg::CSR_TARGET_BER);

   always_comb begin
      case (bts_pkg::csr_index_type'(csr_paddr[3]))
         bts_pkg::CSR_TARGET_BER: csr_prdata = {1'b0, target_ff};
         default:                 csr_prdata = '0;
      endcase
   end

   // ---------------- handshake ----------------
   assign advance   = in_valid_ff && (!out_valid_ff || rsp_ready);
   assign req_ready = !in_valid_ff || advance;

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else if (req_valid && req_ready) begin
         in_valid_ff <= 1'b1;
      end else if (advance) begin
         in_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (req_valid && req_ready) begin
         in_ber_ff    <= req_measured_ber;
         in_failed_ff <= req_measure_failed;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
      end else if (advance) begin
         out_valid_ff <= 1'b1;
      end else if (rsp_ready) begin
         out_valid_ff <= 1'b0;
      end
   end

   // ---------------- step and tracking logic ----------------
   always_comb begin
      ber64     = {1'b0, in_ber_ff};
      tgt64     = {1'b0, target_ff};
      d         = bts_pkg::ber_dist(ber64, tgt64);
      is_retry  = in_failed_ff &&
                  (retry_ff < bts_pkg::RETRY_WIDTH'(MAX_RETRIES));
      has_rate  = !in_failed_ff;
      track     = has_rate && (in_ber_ff != '0);
      ge_target = ber64 >= tgt64;
      upd_above = track && ge_target &&
                  ((d < above_dist_ff) ||
                   ((d == above_dist_ff) && (tap_ff > above_tap_ff)));
      upd_below = track && !ge_target &&
                  ((d < below_dist_ff) ||
                   ((d == below_dist_ff) && (tap_ff < below_tap_ff)));

      // only one side can change per beat, so the final compare needs one operand fresh
      if (upd_above) begin
         pick_above = d < below_dist_ff;
      end else if (upd_below) begin
         pick_above = above_dist_ff < d;
      end else begin
         pick_above = above_dist_ff < below_dist_ff;
      end

      above_le_one    = upd_above ? (ber64 <= bts_pkg::BER_ONE)
                                  : (above_ber_ff <= bts_pkg::BER_ONE);
      below_lt_target = upd_below ? 1'b1 : (below_ber_ff < tgt64);

      new_above_tap = upd_above ? tap_ff : above_tap_ff;
      new_below_tap = upd_below ? tap_ff : below_tap_ff;
      chosen_in     = pick_above ? new_above_tap : new_below_tap;

      up       = has_rate && (ber64 > tgt64);
      over     = up && (idx_ff == '0);
      tap_in   = up ? (tap_ff + step_ff) : (tap_ff - step_ff);
      next_idx = {1'b0, idx_ff} + (IDX_W + 1)'(1);
      done     = over || (next_idx >= (IDX_W + 1)'(SCAN_STEPS));
   end

   // ---------------- scan state ----------------
   always_ff @(posedge clock) begin
      if (reset) begin
         target_ff     <= bts_pkg::TARGET_RESET;
         tap_ff        <= TAP_START;
         step_ff       <= STEP_START;
         idx_ff        <= '0;
         retry_ff      <= '0;
         above_ber_ff  <= bts_pkg::BER_NONE;
         below_ber_ff  <= bts_pkg::BER_NONE;
         above_dist_ff <= bts_pkg::DIST_RESET;
         below_dist_ff <= bts_pkg::DIST_RESET;
         above_tap_ff  <= '0;
         below_tap_ff  <= '0;
      end else if (csr_wr) begin
         // stored distances follow the new target
         target_ff     <= wr_target;
         above_dist_ff <= bts_pkg::ber_dist(above_ber_ff, {1'b0, wr_target});
         below_dist_ff <= bts_pkg::ber_dist(below_ber_ff, {1'b0, wr_target});
      end else if (advance) begin
         if (is_retry) begin
            retry_ff <= retry_ff + bts_pkg::RETRY_WIDTH'(1);
         end else if (done) begin
            tap_ff        <= TAP_START;
            step_ff       <= STEP_START;
            idx_ff        <= '0;
            retry_ff      <= '0;
            above_ber_ff  <= bts_pkg::BER_NONE;
            below_ber_ff  <= bts_pkg::BER_NONE;
            above_dist_ff <= bts_pkg::BER_NONE - tgt64;
            below_dist_ff <= bts_pkg::BER_NONE - tgt64;
            above_tap_ff  <= '0;
            below_tap_ff  <= '0;
         end else begin
            tap_ff   <= tap_in;
            step_ff  <= step_ff >> 1;
            idx_ff   <= next_idx[IDX_W-1:0];
            retry_ff <= '0;
            if (upd_above) begin
               above_ber_ff  <= ber64;
               above_dist_ff <= d;
               above_tap_ff  <= tap_ff;
            end
            if (upd_below) begin
               below_ber_ff  <= ber64;
               below_dist_ff <= d;
               below_tap_ff  <= tap_ff;
            end
         end
      end
   end

   // ---------------- result register ----------------
   always_ff @(posedge clock) begin
      if (advance) begin
         if (is_retry) begin
            out_next_tap_ff <= tap_ff;
            out_retrying_ff <= 1'b1;
            out_done_ff     <= 1'b0;
            out_over_ff     <= 1'b0;
            out_chosen_ff   <= '0;
            out_fit_ff      <= 1'b0;
         end else if (done) begin
            out_next_tap_ff <= TAP_START;
            out_retrying_ff <= 1'b0;
            out_done_ff     <= 1'b1;
            out_over_ff     <= over;
            out_chosen_ff   <= chosen_in;
            out_fit_ff      <= above_le_one && below_lt_target;
         end else begin
            out_next_tap_ff <= tap_in;
            out_retrying_ff <= 1'b0;
            out_done_ff     <= 1'b0;
            out_over_ff     <= 1'b0;
            out_chosen_ff   <= '0;
            out_fit_ff      <= 1'b0;
         end
      end
   end

   assign rsp_valid                = out_valid_ff;
   assign rsp_next_tap             = out_next_tap_ff;
   assign rsp_retrying             = out_retrying_ff;
   assign rsp_scan_done            = out_done_ff;
   assign rsp_over_target_at_start = out_over_ff;
   assign rsp_chosen_tap           = out_chosen_ff;
   assign rsp_fit_possible         = out_fit_ff;

endmodule

>>> tb/tb.sv
// Self-checking testbench for the tap search block: predicts every result beat and compares it.
module tb;

   localparam int TAP_W       = bts_pkg::TAP_WIDTH_DEFAULT;
   localparam int STEPS       = bts_pkg::SCAN_STEPS_DEFAULT;
   localparam int RETRY_LIMIT = bts_pkg::MAX_RETRIES_DEFAULT;
   localparam int RUN_LIMIT   = 500000;

   localparam logic [TAP_W-1:0] TAP_START  = '1;
   localparam logic [TAP_W-1:0] STEP_START = TAP_W'(1) << (TAP_W - 1);
   localparam bts_pkg::dist_type BER_FIELD_MASK = {1'b0, {63{1'b1}}};
   localparam logic [bts_pkg::CSR_ADDR_WIDTH-1:0] TARGET_BER_ADDR =
      {bts_pkg::CSR_TARGET_BER, 3'b000};

   typedef struct packed {
      logic [TAP_W-1:0] next_tap;
      logic             retrying;
      logic             scan_done;
      logic             over_start;
      logic [TAP_W-1:0] chosen_tap;
      logic             fit_possible;
   } tap_result_type;

   logic clock = 1'b0;
   logic reset = 1'b1;

   logic                                 req_valid = 1'b0;
   logic                                 req_ready;
   bts_pkg::ber_type                     req_measured_ber = '0;
   logic                                 req_measure_failed = 1'b0;
   logic                                 rsp_valid;
   logic                                 rsp_ready = 1'b1;
   logic [TAP_W-1:0]                     rsp_next_tap;
   logic                                 rsp_retrying;
   logic                                 rsp_scan_done;
   logic                                 rsp_over_target_at_start;
   logic [TAP_W-1:0]                     rsp_chosen_tap;
   logic                                 rsp_fit_possible;
   logic                                 csr_psel = 1'b0;
   logic                                 csr_penable = 1'b0;
   logic                                 csr_pwrite = 1'b0;
   logic [bts_pkg::CSR_ADDR_WIDTH-1:0]   csr_paddr = '0;
   logic [bts_pkg::CSR_DATA_WIDTH-1:0]   csr_pwdata = '0;
   logic [bts_pkg::CSR_DATA_WIDTH-1:0]   csr_prdata;
   logic                                 csr_pready;

   ber_target_tap_search uut (
      .clock(clock),
      .reset(reset),
      .req_valid(req_valid),
      .req_ready(req_ready),
      .req_measured_ber(req_measured_ber),
      .req_measure_failed(req_measure_failed),
      .rsp_valid(rsp_valid),
      .rsp_ready(rsp_ready),
      .rsp_next_tap(rsp_next_tap),
      .rsp_retrying(rsp_retrying),
      .rsp_scan_done(rsp_scan_done),
      .rsp_over_target_at_start(rsp_over_target_at_start),
      .rsp_chosen_tap(rsp_chosen_tap),
      .rsp_fit_possible(rsp_fit_possible),
      .csr_psel(csr_psel),
      .csr_penable(csr_penable),
      .csr_pwrite(csr_pwrite),
      .csr_paddr(csr_paddr),
      .csr_pwdata(csr_pwdata),
      .csr_prdata(csr_prdata),
      .csr_pready(csr_pready)
   );

   // search state mirrored by the predictor
   bts_pkg::dist_type target;
   logic [TAP_W-1:0]  srch_tap;
   logic [TAP_W-1:0]  srch_step;
   int unsigned       srch_index;
   int unsigned       srch_retries;
   bts_pkg::dist_type above_ber;
   logic [TAP_W-1:0]  above_tap;
   bts_pkg::dist_type below_ber;
   logic [TAP_W-1:0]  below_tap;

   tap_result_type tap_results_due[$];
   int unsigned    mismatches = 0;
   int unsigned    results_seen = 0;
   int unsigned    cycles_run = 0;
   int unsigned    stall_left = 0;
   bit             steady = 1'b0;

   initial begin
      forever #6 clock = ~clock;
   end

   always @(posedge clock) begin
      cycles_run <= cycles_run + 1;
      if (cycles_run == RUN_LIMIT) begin
         $display("simulation failed");
         $finish;
      end
   end

   task automatic report_mismatch(input string what, input logic [63:0] want, got);
      $display("mismatch at result beat %0d, %s: expected 0x%0h, got 0x%0h",
               results_seen, what, want, got);
      mismatches++;
   endtask

   function automatic bts_pkg::dist_type rate_gap(input bts_pkg::dist_type a,
                                                  input bts_pkg::dist_type b);
      return (a >= b) ? a - b : b - a;
   endfunction

   function automatic void rearm_search();
      srch_tap     = TAP_START;
      srch_step    = STEP_START;
      srch_index   = 0;
      srch_retries = 0;
      above_ber    = bts_pkg::BER_NONE;
      above_tap    = '0;
      below_ber    = bts_pkg::BER_NONE;
      below_tap    = '0;
   endfunction

   // keep the nonzero rates nearest the target from above and from below
   function automatic void note_point(input bts_pkg::dist_type ber,
                                      input logic [TAP_W-1:0] tap);
      bts_pkg::dist_type d;
      bts_pkg::dist_type held;
      if (ber == 0) return;
      d = rate_gap(ber, target);
      if (ber >= target) begin
         held = rate_gap(above_ber, target);
         if (d < held || (d == held && tap > above_tap)) begin
            above_ber = ber;
            above_tap = tap;
         end
      end else begin
         held = rate_gap(below_ber, target);
         if (d < held || (d == held && tap < below_tap)) begin
            below_ber = ber;
            below_tap = tap;
         end
      end
   endfunction

   function automatic tap_result_type predict_step(input bts_pkg::ber_type ber,
                                                   input logic failed);
      tap_result_type r;
      bts_pkg::dist_type rate;
      bts_pkg::dist_type da;
      bts_pkg::dist_type dl;
      logic up;
      logic done;
      logic over;
      r = '0;
      rate = bts_pkg::dist_type'(ber);
      up = 1'b0;
      done = 1'b0;
      over = 1'b0;
      if (failed && srch_retries < RETRY_LIMIT) begin
         srch_retries++;
         r.next_tap = srch_tap;
         r.retrying = 1'b1;
         return r;
      end
      srch_retries = 0;
      if (!failed) begin
         note_point(rate, srch_tap);
         up = rate > target;
      end
      if (srch_index == 0 && up) begin
         done = 1'b1;
         over = 1'b1;
      end else begin
         srch_tap = up ? srch_tap + srch_step : srch_tap - srch_step;
         srch_step = srch_step >> 1;
         if (srch_index + 1 >= STEPS) done = 1'b1;
         else srch_index++;
      end
      if (done) begin
         da = rate_gap(target, above_ber);
         dl = rate_gap(target, below_ber);
         r.scan_done    = 1'b1;
         r.over_start   = over;
         r.chosen_tap   = (da < dl) ? above_tap : below_tap;
         r.fit_possible = above_ber <= bts_pkg::BER_ONE && below_ber < target;
         rearm_search();
      end
      r.next_tap = srch_tap;
      return r;
   endfunction

   always @(posedge clock) begin
      tap_result_type want;
      if (!reset && rsp_valid && rsp_ready) begin
         results_seen++;
         if (tap_results_due.size() == 0) begin
            report_mismatch("result beat with nothing pending", 64'd0, 64'd0);
         end else begin
            want = tap_results_due.pop_front();
            if (rsp_next_tap !== want.next_tap)
               report_mismatch("next_tap", 64'(want.next_tap), 64'(rsp_next_tap));
            if (rsp_retrying !== want.retrying)
               report_mismatch("retrying", 64'(want.retrying), 64'(rsp_retrying));
            if (rsp_scan_done !== want.scan_done)
               report_mismatch("scan_done", 64'(want.scan_done), 64'(rsp_scan_done));
            if (rsp_over_target_at_start !== want.over_start)
               report_mismatch("over_target_at_start", 64'(want.over_start),
                               64'(rsp_over_target_at_start));
            if (rsp_chosen_tap !== want.chosen_tap)
               report_mismatch("chosen_tap", 64'(want.chosen_tap), 64'(rsp_chosen_tap));
            if (rsp_fit_possible !== want.fit_possible)
               report_mismatch("fit_possible", 64'(want.fit_possible),
                               64'(rsp_fit_possible));
         end
      end
   end

   // result-side back-pressure: mostly short stalls, now and then a long one
   always @(negedge clock) begin
      if (stall_left == 0 && !steady && $urandom_range(0, 99) < 30)
         stall_left = ($urandom_range(0, 9) == 0) ? $urandom_range(8, 40)
                                                  : $urandom_range(1, 3);
      if (stall_left != 0) begin
         rsp_ready <= 1'b0;
         stall_left--;
      end else begin
         rsp_ready <= 1'b1;
      end
   end

   // all tasks below start and end just after a falling edge
   task automatic send_measurement(input bts_pkg::ber_type ber, input logic failed);
      int unsigned gap;
      int unsigned roll;
      req_valid <= 1'b1;
      req_measured_ber <= ber;
      req_measure_failed <= failed;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
      tap_results_due.push_back(predict_step(ber, failed));
      @(negedge clock);
      roll = $urandom_range(0, 99);
      if (steady || roll < 50) gap = 0;
      else if (roll < 90) gap = $urandom_range(1, 3);
      else gap = $urandom_range(8, 40);
      if (gap != 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(negedge clock);
      end
   endtask

   task automatic wait_results_drained();
      req_valid <= 1'b0;
      while (tap_results_due.size() != 0) @(negedge clock);
      repeat (4) @(negedge clock);
   endtask

   task automatic csr_read_target(output bts_pkg::dist_type value);
      csr_psel <= 1'b1;
      csr_pwrite <= 1'b0;
      csr_paddr <= TARGET_BER_ADDR;
      @(negedge clock);
      csr_penable <= 1'b1;
      @(posedge clock);
      while (!csr_pready) @(posedge clock);
      value = csr_prdata;
      @(negedge clock);
      csr_psel <= 1'b0;
      csr_penable <= 1'b0;
   endtask

   task automatic write_target(input bts_pkg::dist_type value);
      bts_pkg::dist_type got;
      csr_psel <= 1'b1;
      csr_pwrite <= 1'b1;
      csr_paddr <= TARGET_BER_ADDR;
      csr_pwdata <= value;
      @(negedge clock);
      csr_penable <= 1'b1;
      @(posedge clock);
      while (!csr_pready) @(posedge clock);
      target = value & BER_FIELD_MASK;
      @(negedge clock);
      csr_psel <= 1'b0;
      csr_penable <= 1'b0;
      csr_pwrite <= 1'b0;
      @(negedge clock);
      csr_read_target(got);
      if (got !== target) report_mismatch("target_ber readback", target, got);
   endtask

   // rates cluster around the target so ties and near misses are common
   function automatic bts_pkg::ber_type pick_rate();
      bts_pkg::dist_type v;
      bts_pkg::dist_type d;
      d = bts_pkg::dist_type'($urandom_range(0, 3));
      case ($urandom_range(0, 9))
         0:       v = '0;
         1:       v = bts_pkg::BER_ONE;
         2, 3:    v = target + d;
         4, 5:    v = (target >= d) ? target - d : '0;
         6:       v = bts_pkg::dist_type'($urandom_range(1, 1000));
         7:       v = {$urandom, $urandom} & 64'h3FFF_FFFF_FFFF_FFFF;
         default: begin
            d = bts_pkg::dist_type'($urandom);
            v = $urandom_range(0, 1) ? target + d : ((target >= d) ? target - d : '0);
         end
      endcase
      if (v > bts_pkg::BER_ONE) v = bts_pkg::BER_ONE;
      return bts_pkg::ber_type'(v);
   endfunction

   // mostly keep the first step at or under target so scans run to the end
   function automatic bts_pkg::ber_type steered_rate();
      bts_pkg::ber_type v;
      v = pick_rate();
      if (srch_index == 0 && srch_retries == 0 && $urandom_range(0, 3) != 0 &&
          bts_pkg::dist_type'(v) > target)
         v = bts_pkg::ber_type'(target);
      return v;
   endfunction

   task automatic test_reset_target();
      bts_pkg::dist_type got;
      csr_read_target(got);
      if (got !== bts_pkg::dist_type'(bts_pkg::TARGET_RESET))
         report_mismatch("target_ber after reset",
                         bts_pkg::dist_type'(bts_pkg::TARGET_RESET), got);
   endtask

   task automatic test_over_at_start();
      send_measurement(bts_pkg::ber_type'(bts_pkg::BER_ONE), 1'b0);
   endtask

   // failures up to and past the retry limit, zero rate, rates at and beside the
   // target, full scale, and repeated rates at different taps for the tie rules
   task automatic test_edge_scan();
      bts_pkg::dist_type t;
      t = target;
      send_measurement(63'h2AAA_AAAA_AAAA_AAAA, 1'b1);
      send_measurement(63'h1555_5555_5555_5555, 1'b1);
      send_measurement(bts_pkg::ber_type'(bts_pkg::BER_ONE), 1'b1);
      send_measurement('0, 1'b1);
      send_measurement('0, 1'b0);
      send_measurement(bts_pkg::ber_type'(t), 1'b0);
      send_measurement(bts_pkg::ber_type'(t + 1), 1'b0);
      send_measurement(bts_pkg::ber_type'(t - 1), 1'b0);
      send_measurement(63'd1, 1'b0);
      send_measurement(bts_pkg::ber_type'(bts_pkg::BER_ONE), 1'b0);
      send_measurement(bts_pkg::ber_type'(t + 1), 1'b0);
      send_measurement(bts_pkg::ber_type'(t - 1), 1'b0);
      send_measurement('0, 1'b0);
      send_measurement('0, 1'b0);
   endtask

   // a whole scan of zero rates leaves both markers in place
   task automatic test_no_point();
      wait_results_drained();
      write_target('0);
      repeat (STEPS) send_measurement('0, 1'b0);
   endtask

   function automatic bts_pkg::dist_type phase_target(input int unsigned phase);
      case (phase)
         0:       return bts_pkg::BER_ONE;
         1:       return '0;
         2:       return 64'd1;
         3:       return bts_pkg::dist_type'(bts_pkg::TARGET_RESET);
         4:       return bts_pkg::BER_ONE - 1;
         5:       return bts_pkg::dist_type'($urandom);
         default: return {$urandom, $urandom} & 64'h3FFF_FFFF_FFFF_FFFF;
      endcase
   endfunction

   task automatic test_random_scans(input int unsigned beats);
      int unsigned per_phase;
      int unsigned sent;
      int unsigned burst;
      per_phase = beats / 8;
      for (int unsigned p = 0; p < 8; p++) begin
         wait_results_drained();
         write_target(phase_target(p));
         steady = ($urandom_range(0, 3) == 0);
         sent = 0;
         while (sent < per_phase) begin
            if ($urandom_range(0, 9) == 0) begin
               burst = $urandom_range(1, 5);
               repeat (burst) send_measurement(pick_rate(), 1'b1);
               sent += burst;
            end else begin
               send_measurement(steered_rate(), 1'b0);
               sent++;
            end
            if ($urandom_range(0, 59) == 0) wait_results_drained();
         end
      end
      steady = 1'b0;
   endtask

   initial begin
      target = bts_pkg::dist_type'(bts_pkg::TARGET_RESET);
      rearm_search();
      repeat (11) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);
      test_reset_target();
      test_over_at_start();
      test_edge_scan();
      test_no_point();
      test_random_scans(824);
      wait_results_drained();
      if (mismatches == 0) begin
         $display("simulation ok");
      end else begin
         $display("simulation failed");
      end
      $finish;
   end

endmodule
